// ----- src/pva_pkg.sv -----
// Shared types and constants for the polyphonic voice allocator.
// No dependencies; used by pva_ctrl, pva_datapath and the top level.
package pva_pkg;

   localparam int NUM_VOICES  = 16;
   localparam int VOICE_W     = 4;
   localparam int NOTE_W      = 7;
   localparam int SLOT_NOTE_W = 8;
   localparam int MAP_DEPTH   = 128;
   localparam int TIME_W      = 64;
   localparam int SPREAD_W    = 9;
   localparam int PAN_W       = 10;
   localparam int MASK_W      = 16;
   localparam int GROUP_W     = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int FULL_PAN    = 256;

   // slot note with the top bit set means the slot holds no note
   localparam logic [SLOT_NOTE_W-1:0] NOTE_NONE = 8'h80;
   localparam logic [NOTE_W-1:0]      NOTE_MASK = 7'h7F;

   typedef enum logic [1:0] {
      FUNC_NOTE_ON     = 2'd0,
      FUNC_NOTE_ON_GRP = 2'd1,
      FUNC_NOTE_OFF    = 2'd2,
      FUNC_SWEEP       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_RETRIG  = 3'd1,
      ACT_START   = 3'd2,
      ACT_STEAL   = 3'd3,
      ACT_RELEASE = 3'd4,
      ACT_SWEPT   = 3'd5
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAN_SPREAD   = 1'b0,
      CSR_VOICE_GROUPS = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_PTR,
      ST_CHECK,
      ST_SCAN,
      ST_PICK,
      ST_STEAL,
      ST_ALLOC,
      ST_SW_CHK,
      ST_SW_MAP,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_MAP_RD,
      OP_PTR_MAP,
      OP_RETRIG,
      OP_RELEASE,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_PICK,
      OP_STEAL_CLR,
      OP_ALLOC,
      OP_SW_CHK,
      OP_SW_MAP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     match;        // mapped voice is active and holds the note
      logic     grp_ok;       // mapped voice lies in the requested group
      logic     ptr_last;
      logic     idle_found;
      logic     cand_found;
      logic     sw_need_map;
      logic     out_free;
   } dp_status_type;

endpackage

// ----- src/pva_datapath.sv -----
// Datapath of the voice allocator: slot state, note map memory, search
// registers, result and output registers. Depends on pva_pkg.
module pva_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pva_pkg::dp_cmd_type                 cmd,
   output pva_pkg::dp_status_type              status,
   input  logic [1:0]                          req_func,
   input  logic [pva_pkg::NOTE_W-1:0]          req_note,
   input  logic [pva_pkg::GROUP_W-1:0]         req_group,
   input  logic [pva_pkg::MASK_W-1:0]          req_sounding_mask,
   input  logic [pva_pkg::MASK_W-1:0]          req_releasing_mask,
   input  logic                                csr_we,
   input  logic [pva_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pva_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_action,
   output logic [pva_pkg::VOICE_W-1:0]         rsp_voice,
   output logic signed [pva_pkg::PAN_W-1:0]    rsp_pan_value,
   output logic                                rsp_stolen_valid,
   output logic [pva_pkg::NOTE_W-1:0]          rsp_stolen_note,
   output logic [pva_pkg::MASK_W-1:0]          rsp_retired_mask
);

   localparam int NV = pva_pkg::NUM_VOICES;
   localparam int VW = pva_pkg::VOICE_W;
   localparam int TW = pva_pkg::TIME_W;

   // latched request
   pva_pkg::func_type                  func_ff, func_in;
   logic [pva_pkg::NOTE_W-1:0]         note_ff, note_in;
   logic [pva_pkg::GROUP_W-1:0]        grp_ff, grp_in;
   logic [NV-1:0]                      snd_ff, snd_in;
   logic [NV-1:0]                      relm_ff, relm_in;

   // configuration
   logic [pva_pkg::SPREAD_W-1:0]       spread_ff, spread_in;
   logic [pva_pkg::CSR_DATA_W-1:0]     groups_ff, groups_in;

   // voice slots
   logic [pva_pkg::SLOT_NOTE_W-1:0]    slot_note_ff [NV];
   logic [pva_pkg::SLOT_NOTE_W-1:0]    slot_note_in [NV];
   logic [NV-1:0]                      slot_active_ff, slot_active_in;
   logic [TW-1:0]                      slot_time_ff [NV];
   logic [TW-1:0]                      slot_time_in [NV];
   logic [TW-1:0]                      time_ff, time_in;

   // slot pointer, doubles as scan counter
   logic [VW-1:0]                      ptr_ff, ptr_in;

   // search results
   logic                               idle_fnd_ff, idle_fnd_in;
   logic [VW-1:0]                      idle_idx_ff, idle_idx_in;
   logic                               rel_fnd_ff, rel_fnd_in;
   logic [VW-1:0]                      rel_idx_ff, rel_idx_in;
   logic [TW-1:0]                      rel_t_ff, rel_t_in;
   logic                               old_fnd_ff, old_fnd_in;
   logic [VW-1:0]                      old_idx_ff, old_idx_in;
   logic [TW-1:0]                      old_t_ff, old_t_in;
   logic                               steal_ff, steal_in;
   logic [pva_pkg::NOTE_W-1:0]         swnote_ff, swnote_in;

   // note map: voice data in memory, valid bits in flops
   logic [VW-1:0]                      map_mem [pva_pkg::MAP_DEPTH];
   logic [pva_pkg::MAP_DEPTH-1:0]      map_vld_ff;
   logic                               rd_vld_ff;
   logic [VW-1:0]                      rd_voice_ff;
   logic                               map_rd, map_set, map_clr;
   logic [pva_pkg::NOTE_W-1:0]         map_addr;

   // pending result
   pva_pkg::action_type                res_action_ff, res_action_in;
   logic [VW-1:0]                      res_voice_ff, res_voice_in;
   logic signed [pva_pkg::PAN_W-1:0]   res_pan_ff, res_pan_in;
   logic                               res_sv_ff, res_sv_in;
   logic [pva_pkg::NOTE_W-1:0]         res_sn_ff, res_sn_in;
   logic [pva_pkg::MASK_W-1:0]         res_ret_ff, res_ret_in;

   // output register
   logic                               out_valid_ff, out_valid_in;
   pva_pkg::action_type                out_action_ff, out_action_in;
   logic [VW-1:0]                      out_voice_ff, out_voice_in;
   logic signed [pva_pkg::PAN_W-1:0]   out_pan_ff, out_pan_in;
   logic                               out_sv_ff, out_sv_in;
   logic [pva_pkg::NOTE_W-1:0]         out_sn_ff, out_sn_in;
   logic [pva_pkg::MASK_W-1:0]         out_ret_ff, out_ret_in;

   // slot read at the pointer
   logic [pva_pkg::SLOT_NOTE_W-1:0]    cur_note;
   logic                               cur_active;
   logic [TW-1:0]                      cur_time;
   logic [pva_pkg::GROUP_W-1:0]        cur_grp;
   logic                               grouped, in_grp, snd_bit, rel_bit;
   logic [TW-1:0]                      time_nx;
   logic [pva_pkg::SPREAD_W-1:0]       spread_sat;
   logic signed [pva_pkg::PAN_W-1:0]   pan_mag, pan_calc;
   logic                               ptr_ok;

   assign cur_note   = slot_note_ff[ptr_ff];
   assign cur_active = slot_active_ff[ptr_ff];
   assign cur_time   = slot_time_ff[ptr_ff];
   assign cur_grp    = groups_ff[{ptr_ff, 1'b0} +: pva_pkg::GROUP_W];
   assign grouped    = (func_ff == pva_pkg::FUNC_NOTE_ON_GRP);
   assign in_grp     = !grouped || (cur_grp == grp_ff);
   assign snd_bit    = snd_ff[ptr_ff];
   assign rel_bit    = relm_ff[ptr_ff];
   assign time_nx    = time_ff + TW'(1);
   assign ptr_ok     = ({1'b0, ptr_ff} < (VW+1)'(NV));

   assign spread_sat = (spread_ff > pva_pkg::SPREAD_W'(pva_pkg::FULL_PAN)) ?
                       pva_pkg::SPREAD_W'(pva_pkg::FULL_PAN) : spread_ff;
   assign pan_mag    = $signed({1'b0, spread_sat});
   assign pan_calc   = ptr_ff[0] ? pan_mag : -pan_mag;   // odd voice pans right

   always_comb begin
      status.func        = func_ff;
      status.match       = rd_vld_ff && ptr_ok && cur_active &&
                           (cur_note == {1'b0, note_ff});
      status.grp_ok      = in_grp;
      status.ptr_last    = (ptr_ff == VW'(NV - 1));
      status.idle_found  = idle_fnd_ff;
      status.cand_found  = idle_fnd_ff || rel_fnd_ff || old_fnd_ff;
      status.sw_need_map = cur_active && !snd_bit && !cur_note[pva_pkg::SLOT_NOTE_W-1];
      status.out_free    = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      func_in        = func_ff;
      note_in        = note_ff;
      grp_in         = grp_ff;
      snd_in         = snd_ff;
      relm_in        = relm_ff;
      spread_in      = spread_ff;
      groups_in      = groups_ff;
      slot_note_in   = slot_note_ff;
      slot_active_in = slot_active_ff;
      slot_time_in   = slot_time_ff;
      time_in        = time_ff;
      ptr_in         = ptr_ff;
      idle_fnd_in    = idle_fnd_ff;
      idle_idx_in    = idle_idx_ff;
      rel_fnd_in     = rel_fnd_ff;
      rel_idx_in     = rel_idx_ff;
      rel_t_in       = rel_t_ff;
      old_fnd_in     = old_fnd_ff;
      old_idx_in     = old_idx_ff;
      old_t_in       = old_t_ff;
      steal_in       = steal_ff;
      swnote_in      = swnote_ff;
      res_action_in  = res_action_ff;
      res_voice_in   = res_voice_ff;
      res_pan_in     = res_pan_ff;
      res_sv_in      = res_sv_ff;
      res_sn_in      = res_sn_ff;
      res_ret_in     = res_ret_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_action_in  = out_action_ff;
      out_voice_in   = out_voice_ff;
      out_pan_in     = out_pan_ff;
      out_sv_in      = out_sv_ff;
      out_sn_in      = out_sn_ff;
      out_ret_in     = out_ret_ff;
      map_rd         = 1'b0;
      map_set        = 1'b0;
      map_clr        = 1'b0;
      map_addr       = note_ff;

      if (csr_we) begin
         case (pva_pkg::csr_idx_type'(csr_index))
            pva_pkg::CSR_PAN_SPREAD:   spread_in = csr_wdata[pva_pkg::SPREAD_W-1:0];
            pva_pkg::CSR_VOICE_GROUPS: groups_in = csr_wdata;
            default: ;
         endcase
      end

      case (cmd.op)
         pva_pkg::OP_ACCEPT: begin
            func_in       = pva_pkg::func_type'(req_func);
            note_in       = req_note;
            grp_in        = req_group;
            snd_in        = req_sounding_mask[NV-1:0];
            relm_in       = req_releasing_mask[NV-1:0];
            ptr_in        = '0;
            res_action_in = (pva_pkg::func_type'(req_func) == pva_pkg::FUNC_SWEEP) ?
                            pva_pkg::ACT_SWEPT : pva_pkg::ACT_NONE;
            res_voice_in  = '0;
            res_pan_in    = '0;
            res_sv_in     = 1'b0;
            res_sn_in     = '0;
            res_ret_in    = '0;
         end
         pva_pkg::OP_MAP_RD: begin
            map_rd = 1'b1;
         end
         pva_pkg::OP_PTR_MAP: begin
            ptr_in = rd_voice_ff;
         end
         pva_pkg::OP_RETRIG: begin
            time_in              = time_nx;
            slot_time_in[ptr_ff] = time_nx;
            res_action_in        = pva_pkg::ACT_RETRIG;
            res_voice_in         = ptr_ff;
         end
         pva_pkg::OP_RELEASE: begin
            map_clr       = 1'b1;
            res_action_in = pva_pkg::ACT_RELEASE;
            res_voice_in  = ptr_ff;
         end
         pva_pkg::OP_SCAN_INIT: begin
            ptr_in      = '0;
            idle_fnd_in = 1'b0;
            rel_fnd_in  = 1'b0;
            old_fnd_in  = 1'b0;
         end
         pva_pkg::OP_SCAN: begin
            if (in_grp) begin
               if (!snd_bit && !idle_fnd_ff) begin
                  idle_fnd_in = 1'b1;
                  idle_idx_in = ptr_ff;
               end
               // strict compare keeps the lowest index on a tie
               if (rel_bit) begin
                  if (!rel_fnd_ff || (cur_time < rel_t_ff)) begin
                     rel_fnd_in = 1'b1;
                     rel_idx_in = ptr_ff;
                     rel_t_in   = cur_time;
                  end
               end else begin
                  if (!old_fnd_ff || (cur_time < old_t_ff)) begin
                     old_fnd_in = 1'b1;
                     old_idx_in = ptr_ff;
                     old_t_in   = cur_time;
                  end
               end
            end
            ptr_in = ptr_ff + VW'(1);
         end
         pva_pkg::OP_PICK: begin
            steal_in = !idle_fnd_ff;
            if (idle_fnd_ff)     ptr_in = idle_idx_ff;
            else if (rel_fnd_ff) ptr_in = rel_idx_ff;
            else                 ptr_in = old_idx_ff;
         end
         pva_pkg::OP_STEAL_CLR: begin
            map_addr = cur_note[pva_pkg::NOTE_W-1:0];
            if (!cur_note[pva_pkg::SLOT_NOTE_W-1]) begin
               map_clr   = 1'b1;
               res_sv_in = 1'b1;
               res_sn_in = cur_note[pva_pkg::NOTE_W-1:0];
            end
         end
         pva_pkg::OP_ALLOC: begin
            map_set                = 1'b1;
            slot_note_in[ptr_ff]   = {1'b0, note_ff};
            slot_active_in[ptr_ff] = 1'b1;
            time_in                = time_nx;
            slot_time_in[ptr_ff]   = time_nx;
            res_action_in          = steal_ff ? pva_pkg::ACT_STEAL : pva_pkg::ACT_START;
            res_voice_in           = ptr_ff;
            res_pan_in             = steal_ff ? '0 : pan_calc;
         end
         pva_pkg::OP_SW_CHK: begin
            map_addr = cur_note[pva_pkg::NOTE_W-1:0];
            if (cur_active && !snd_bit) begin
               slot_active_in[ptr_ff] = 1'b0;
               slot_note_in[ptr_ff]   = pva_pkg::NOTE_NONE;
               res_ret_in[ptr_ff]     = 1'b1;
            end
            if (status.sw_need_map) begin
               map_rd    = 1'b1;
               swnote_in = cur_note[pva_pkg::NOTE_W-1:0];
            end else begin
               ptr_in = ptr_ff + VW'(1);
            end
         end
         pva_pkg::OP_SW_MAP: begin
            // only clear the entry if it still points at this voice
            map_addr = swnote_ff;
            map_clr  = rd_vld_ff && (rd_voice_ff == ptr_ff);
            ptr_in   = ptr_ff + VW'(1);
         end
         pva_pkg::OP_EMIT: begin
            out_valid_in  = 1'b1;
            out_action_in = res_action_ff;
            out_voice_in  = res_voice_ff;
            out_pan_in    = res_pan_ff;
            out_sv_in     = res_sv_ff;
            out_sn_in     = res_sn_ff;
            out_ret_in    = res_ret_ff;
         end
         default: ;
      endcase
   end

   // note map memory
   always_ff @(posedge clock) begin
      if (map_set) begin
         map_mem[map_addr] <= ptr_ff;
      end
      if (map_rd) begin
         rd_voice_ff <= map_mem[map_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (map_set) begin
            map_vld_ff[map_addr] <= 1'b1;
         end else if (map_clr) begin
            map_vld_ff[map_addr] <= 1'b0;
         end
         if (map_rd) begin
            rd_vld_ff <= map_vld_ff[map_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff      <= '0;
         groups_ff      <= '0;
         slot_active_ff <= '0;
         time_ff        <= '0;
         ptr_ff         <= '0;
         idle_fnd_ff    <= 1'b0;
         rel_fnd_ff     <= 1'b0;
         old_fnd_ff     <= 1'b0;
         steal_ff       <= 1'b0;
         out_valid_ff   <= 1'b0;
         func_ff        <= pva_pkg::FUNC_NOTE_ON;
         res_action_ff  <= pva_pkg::ACT_NONE;
         for (int i = 0; i < NV; i++) begin
            slot_note_ff[i] <= pva_pkg::NOTE_NONE;
            slot_time_ff[i] <= '0;
         end
      end else begin
         spread_ff      <= spread_in;
         groups_ff      <= groups_in;
         slot_active_ff <= slot_active_in;
         time_ff        <= time_in;
         ptr_ff         <= ptr_in;
         idle_fnd_ff    <= idle_fnd_in;
         rel_fnd_ff     <= rel_fnd_in;
         old_fnd_ff     <= old_fnd_in;
         steal_ff       <= steal_in;
         out_valid_ff   <= out_valid_in;
         func_ff        <= func_in;
         res_action_ff  <= res_action_in;
         slot_note_ff   <= slot_note_in;
         slot_time_ff   <= slot_time_in;
      end
   end

   always_ff @(posedge clock) begin
      note_ff       <= note_in;
      grp_ff        <= grp_in;
      snd_ff        <= snd_in;
      relm_ff       <= relm_in;
      idle_idx_ff   <= idle_idx_in;
      rel_idx_ff    <= rel_idx_in;
      rel_t_ff      <= rel_t_in;
      old_idx_ff    <= old_idx_in;
      old_t_ff      <= old_t_in;
      swnote_ff     <= swnote_in;
      res_voice_ff  <= res_voice_in;
      res_pan_ff    <= res_pan_in;
      res_sv_ff     <= res_sv_in;
      res_sn_ff     <= res_sn_in;
      res_ret_ff    <= res_ret_in;
      out_action_ff <= out_action_in;
      out_voice_ff  <= out_voice_in;
      out_pan_ff    <= out_pan_in;
      out_sv_ff     <= out_sv_in;
      out_sn_ff     <= out_sn_in;
      out_ret_ff    <= out_ret_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_action       = out_action_ff;
   assign rsp_voice        = out_voice_ff;
   assign rsp_pan_value    = out_pan_ff;
   assign rsp_stolen_valid = out_sv_ff;
   assign rsp_stolen_note  = out_sn_ff;
   assign rsp_retired_mask = out_ret_ff;

endmodule

// ----- src/pva_ctrl.sv -----
// Sequencer of the voice allocator: walks one event through lookup,
// voice scan, allocation or sweep. Depends on pva_pkg.
module pva_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pva_pkg::dp_status_type status,
   output pva_pkg::dp_cmd_type    cmd,
   output pva_pkg::state_type     state
);

   pva_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pva_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = pva_pkg::OP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         pva_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = pva_pkg::OP_ACCEPT;
               state_in = pva_pkg::ST_START;
            end
         end
         pva_pkg::ST_START: begin
            if (status.func == pva_pkg::FUNC_SWEEP) begin
               state_in = pva_pkg::ST_SW_CHK;
            end else begin
               cmd.op   = pva_pkg::OP_MAP_RD;
               state_in = pva_pkg::ST_PTR;
            end
         end
         pva_pkg::ST_PTR: begin
            cmd.op   = pva_pkg::OP_PTR_MAP;
            state_in = pva_pkg::ST_CHECK;
         end
         pva_pkg::ST_CHECK: begin
            if (status.func == pva_pkg::FUNC_NOTE_OFF) begin
               if (status.match) cmd.op = pva_pkg::OP_RELEASE;
               state_in = pva_pkg::ST_DONE;
            end else if (status.match && status.grp_ok) begin
               cmd.op   = pva_pkg::OP_RETRIG;
               state_in = pva_pkg::ST_DONE;
            end else begin
               cmd.op   = pva_pkg::OP_SCAN_INIT;
               state_in = pva_pkg::ST_SCAN;
            end
         end
         pva_pkg::ST_SCAN: begin
            cmd.op = pva_pkg::OP_SCAN;
            if (status.ptr_last) state_in = pva_pkg::ST_PICK;
         end
         pva_pkg::ST_PICK: begin
            cmd.op = pva_pkg::OP_PICK;
            if (!status.cand_found)     state_in = pva_pkg::ST_DONE;
            else if (status.idle_found) state_in = pva_pkg::ST_ALLOC;
            else                        state_in = pva_pkg::ST_STEAL;
         end
         pva_pkg::ST_STEAL: begin
            cmd.op   = pva_pkg::OP_STEAL_CLR;
            state_in = pva_pkg::ST_ALLOC;
         end
         pva_pkg::ST_ALLOC: begin
            cmd.op   = pva_pkg::OP_ALLOC;
            state_in = pva_pkg::ST_DONE;
         end
         pva_pkg::ST_SW_CHK: begin
            cmd.op = pva_pkg::OP_SW_CHK;
            if (status.sw_need_map) state_in = pva_pkg::ST_SW_MAP;
            else if (status.ptr_last) state_in = pva_pkg::ST_DONE;
         end
         pva_pkg::ST_SW_MAP: begin
            cmd.op = pva_pkg::OP_SW_MAP;
            state_in = status.ptr_last ? pva_pkg::ST_DONE : pva_pkg::ST_SW_CHK;
         end
         pva_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.op   = pva_pkg::OP_EMIT;
               state_in = pva_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pva_pkg::ST_IDLE;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ----- src/polyphonic_voice_allocator.sv -----
// Top level of the polyphonic voice allocator: sequencer plus datapath.
// Depends on pva_pkg, pva_ctrl and pva_datapath.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  func, note, group, sounding/releasing masks
//   rsp_      out        rsp_valid / rsp_ready  action, voice, pan, stolen note, retired mask
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// One event at a time. Note off and retrigger go from accept through the map lookup to
// the result; other note-ons scan the 16 voice slots one per cycle.
// A sweep checks one slot per cycle, but each slot whose note map entry must be checked
// adds a map step that holds the sweep (single map port). The result sits in an output
// register, so a new event is taken while the last result is still waiting; a stall
// on rsp_ready only holds the block once the next result is ready. Synchronous
// reset clears all slots and the note map valid bits.
module polyphonic_voice_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [pva_pkg::NOTE_W-1:0]          req_note,
   input  logic [pva_pkg::GROUP_W-1:0]         req_group,
   input  logic [pva_pkg::MASK_W-1:0]          req_sounding_mask,
   input  logic [pva_pkg::MASK_W-1:0]          req_releasing_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_action,
   output logic [pva_pkg::VOICE_W-1:0]         rsp_voice,
   output logic signed [pva_pkg::PAN_W-1:0]    rsp_pan_value,
   output logic                                rsp_stolen_valid,
   output logic [pva_pkg::NOTE_W-1:0]          rsp_stolen_note,
   output logic [pva_pkg::MASK_W-1:0]          rsp_retired_mask,
   input  logic                                csr_we,
   input  logic [pva_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pva_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   pva_pkg::dp_cmd_type    cmd;
   pva_pkg::dp_status_type status;
   pva_pkg::state_type     state;

   pva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   pva_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_func           (req_func),
      .req_note           (req_note),
      .req_group          (req_group),
      .req_sounding_mask  (req_sounding_mask),
      .req_releasing_mask (req_releasing_mask),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_voice          (rsp_voice),
      .rsp_pan_value      (rsp_pan_value),
      .rsp_stolen_valid   (rsp_stolen_valid),
      .rsp_stolen_note    (rsp_stolen_note),
      .rsp_retired_mask   (rsp_retired_mask)
   );

   // one event in flight: no second transfer right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted twice in a row");

   // a new result is only loaded while the sequencer is finishing an event
   a_emit_from_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pva_pkg::OP_EMIT) |-> (state == pva_pkg::ST_DONE))
      else $error("result loaded outside of the done state");

   a_retired_only_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action != pva_pkg::ACT_SWEPT)) |-> (rsp_retired_mask == '0))
      else $error("retired mask set on a non-sweep result");

   a_stolen_only_steal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stolen_valid) |->
      ((rsp_action == pva_pkg::ACT_STEAL) && (rsp_pan_value == '0)))
      else $error("stolen note reported without a centered steal");

endmodule
